>>> design/windowed_event_time_counter_assert.svh
// Assertion macros for the windowed event time counter.
`ifndef WINDOWED_EVENT_TIME_COUNTER_ASSERT_SVH
`define WINDOWED_EVENT_TIME_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WETC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WETC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/wetc_pkg.sv
// Shared types and constants for the windowed event time counter.
package wetc_pkg;

    localparam int WIN_W  = 12;
    localparam int END_W  = 13;
    localparam int TIME_W = 17;
    localparam int IDX_W  = 11;
    localparam int GRP_W  = 3;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 12'd60;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Query command from the front end to the scanner.
    typedef struct packed {
        logic             go;
        logic             empty;
        logic [WIN_W-1:0] wstart;
        logic [END_W-1:0] wend;
    } scan_cmd_t;

    // Scanner status back to the front end.
    typedef struct packed {
        logic busy;
        logic done;
    } scan_stat_t;

endpackage

>>> design/wetc_store.sv
// Timestamp store: single-port synchronous memory, registered read data.
module wetc_store
    import wetc_pkg::*;
#(
    parameter int DEPTH  = 1280,
    parameter int ADDR_W = 11
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        addr,
    input  logic signed [TIME_W-1:0] wdata,
    output logic signed [TIME_W-1:0] rdata
);

    logic signed [TIME_W-1:0] mem [DEPTH];
    logic signed [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/wetc_scan.sv
// Query scanner: walks an address range, compares each word, counts hits.
module wetc_scan
    import wetc_pkg::*;
#(
    parameter int ADDR_W = 11
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  scan_cmd_t                cmd,
    input  logic [ADDR_W-1:0]        first_addr,
    input  logic [ADDR_W-1:0]        last_addr,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic signed [TIME_W-1:0] rd_data,
    output scan_stat_t               stat,
    output logic [CNT_W-1:0]         count
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [ADDR_W-1:0] last_reg,   last_next;
    logic [WIN_W-1:0]  wstart_reg, wstart_next;
    logic [END_W-1:0]  wend_reg,   wend_next;
    logic              vld_reg,    vld_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              hit;

    // Negative marks (never happened) fail on the sign bit.
    assign hit = !rd_data[TIME_W-1]
              && (rd_data[TIME_W-2:0] >= 16'(wstart_reg))
              && (rd_data[TIME_W-2:0] <= 16'(wend_reg));

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        last_next   = last_reg;
        wstart_next = wstart_reg;
        wend_next   = wend_reg;
        vld_next    = (state_reg == ST_SCAN);
        cnt_next    = cnt_reg;

        if (vld_reg && hit && (cnt_reg != COUNT_MAX))
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    addr_next   = first_addr;
                    last_next   = last_addr;
                    wstart_next = cmd.wstart;
                    wend_next   = cmd.wend;
                    cnt_next    = '0;
                    state_next  = cmd.empty ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        last_reg   <= last_next;
        wstart_reg <= wstart_next;
        wend_reg   <= wend_next;
    end

    assign rd_en     = (state_reg == ST_SCAN);
    assign rd_addr   = addr_reg;
    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign count     = cnt_reg;

endmodule

>>> design/windowed_event_time_counter.sv
// Top level of the windowed event time counter.
//
// Keeps GROUP_SIZE*NUM_GROUPS event timestamps in one synchronous memory and
// answers window-count queries over them. Pulse start with busy low to hand
// in one word. A load word (kind 0) writes entry_time into entry_index in
// that same cycle; busy never rises, and the next word may follow at once.
// An entry_index past the end of the store is dropped. A query word (kind 1)
// counts the entries of the selected group whose timestamp t satisfies
// window_start <= t <= window_start + window_length; group 0 skips entry 0,
// group NUM_GROUPS covers every entry, and any higher group answers 0. The
// scan reads one entry per cycle from the single memory port. Busy stays high
// through the scan, a drain state and the done state, and the next word is
// accepted only once busy falls; a group above NUM_GROUPS goes straight to
// the done state, so busy is high for a single cycle. The count appears on
// event_count with done high for exactly one cycle, the last busy cycle, and
// is not held: the receiver must take it then, since it cannot stall the
// block. Counts saturate at 2047. The store has no reset; query only entries
// already loaded. Write window_length (reset 60) through cfg_we/cfg_wdata
// only while idle.
`include "windowed_event_time_counter_assert.svh"

module windowed_event_time_counter
    import wetc_pkg::*;
#(
    parameter int GROUP_SIZE = 256,
    parameter int NUM_GROUPS = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic                     cfg_we,
    input  logic [WIN_W-1:0]         cfg_wdata,
    input  logic                     kind,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [TIME_W-1:0] entry_time,
    input  logic [GRP_W-1:0]         group,
    input  logic [WIN_W-1:0]         window_start,
    output logic [CNT_W-1:0]         event_count
);

    localparam int DEPTH  = GROUP_SIZE * NUM_GROUPS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [WIN_W-1:0]         window_length_reg;
    logic                     accept;
    logic                     load_wr;
    logic                     idx_ok;
    logic [31:0]              grp_base;
    logic [ADDR_W-1:0]        first_addr;
    logic [ADDR_W-1:0]        last_addr;
    logic                     range_empty;
    scan_cmd_t                cmd;
    scan_stat_t               stat;
    logic                     scan_rd_en;
    logic [ADDR_W-1:0]        scan_rd_addr;
    logic                     mem_en;
    logic [ADDR_W-1:0]        mem_addr;
    logic signed [TIME_W-1:0] mem_rdata;

    // Window length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_wdata;
        end
    end

    assign accept  = start && !busy;
    assign idx_ok  = (32'(entry_index) < 32'(DEPTH));
    assign load_wr = accept && (kind == KIND_LOAD) && idx_ok;

    // Decode the group into an inclusive address range.
    assign grp_base = 32'(group) * 32'(GROUP_SIZE);

    always_comb
    begin
        first_addr  = '0;
        last_addr   = '0;
        range_empty = 1'b0;
        if (32'(group) < 32'(NUM_GROUPS))
        begin
            first_addr = (group == '0) ? ADDR_W'(1) : ADDR_W'(grp_base);
            last_addr  = ADDR_W'(grp_base + 32'(GROUP_SIZE) - 32'd1);
        end
        else if (32'(group) == 32'(NUM_GROUPS))
        begin
            first_addr = '0;
            last_addr  = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            range_empty = 1'b1;
        end
    end

    assign cmd.go     = accept && (kind == KIND_QUERY);
    assign cmd.empty  = range_empty;
    assign cmd.wstart = window_start;
    assign cmd.wend   = END_W'(window_start) + END_W'(window_length_reg);

    // Loads only land while idle and the scanner reads only while busy,
    // so the single port is never contended.
    assign mem_en   = load_wr || scan_rd_en;
    assign mem_addr = load_wr ? ADDR_W'(entry_index) : scan_rd_addr;

    wetc_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (load_wr),
        .addr  (mem_addr),
        .wdata (entry_time),
        .rdata (mem_rdata)
    );

    wetc_scan #(
        .ADDR_W (ADDR_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .first_addr (first_addr),
        .last_addr  (last_addr),
        .rd_en      (scan_rd_en),
        .rd_addr    (scan_rd_addr),
        .rd_data    (mem_rdata),
        .stat       (stat),
        .count      (event_count)
    );

    assign busy = stat.busy;
    assign done = stat.done;

    `WETC_ASSERT_NOW(a_no_port_clash, load_wr, !scan_rd_en, "load write collides with scan read")
    `WETC_ASSERT_NEXT(a_load_no_busy, accept && (kind == KIND_LOAD), !busy && !done, "load word made the block busy")
    `WETC_ASSERT_NEXT(a_empty_zero, cmd.go && range_empty, done && (event_count == '0), "empty group did not answer zero")
    `WETC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a busy cycle")

endmodule

>>> tb/windowed_event_time_counter_tb.sv
// Testbench for the windowed event time counter: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module windowed_event_time_counter_tb;
    import wetc_pkg::*;

    localparam int GROUP_SIZE  = 256;
    localparam int NUM_GROUPS  = 5;
    localparam int STORE_DEPTH = GROUP_SIZE * NUM_GROUPS;
    // Group code that selects every entry of the store.
    localparam logic [GRP_W-1:0] GROUP_ALL = GRP_W'(NUM_GROUPS);
    localparam logic [GRP_W-1:0] GROUP_TOP = '1;
    localparam logic [WIN_W-1:0] START_MAX = 12'd3600;
    localparam logic [WIN_W-1:0] LEN_MAX   = 12'd3600;
    localparam logic signed [TIME_W-1:0] STAMP_NONE = '1;
    localparam logic signed [TIME_W-1:0] STAMP_TOP  = 17'sd65535;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     done;
    logic                     cfg_we;
    logic [WIN_W-1:0]         cfg_wdata;
    logic                     kind;
    logic [IDX_W-1:0]         entry_index;
    logic signed [TIME_W-1:0] entry_time;
    logic [GRP_W-1:0]         group;
    logic [WIN_W-1:0]         window_start;
    logic [CNT_W-1:0]         event_count;

    // Predictor state: shadow copy of the timestamp store and the window length.
    logic signed [TIME_W-1:0] stamp_mem [STORE_DEPTH];
    logic [WIN_W-1:0]         win_len;
    logic [CNT_W-1:0]         count_q [$];
    int                       errors;
    int                       sender_idle_pct;

    windowed_event_time_counter #(
        .GROUP_SIZE (GROUP_SIZE),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .kind         (kind),
        .entry_index  (entry_index),
        .entry_time   (entry_time),
        .group        (group),
        .window_start (window_start),
        .event_count  (event_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count the entries of a group whose timestamp lies in [ws, ws + win_len].
    function automatic logic [CNT_W-1:0] count_in_window(logic [GRP_W-1:0] grp,
                                                          logic [WIN_W-1:0] ws);
        int lo;
        int hi;
        int hits;
        int wend;
        int stamp;
        if (grp < GRP_W'(NUM_GROUPS))
        begin
            lo = int'(grp) * GROUP_SIZE;
            hi = lo + GROUP_SIZE;
            // group 0 never looks at entry 0
            if (grp == 0)
                lo = 1;
        end
        else if (grp == GROUP_ALL)
        begin
            lo = 0;
            hi = STORE_DEPTH;
        end
        else
        begin
            lo = 0;
            hi = 0;
        end
        hits = 0;
        wend = int'(ws) + int'(win_len);
        for (int i = lo; i < hi; i++)
        begin
            stamp = int'(stamp_mem[i]);
            if (stamp >= int'(ws) && stamp <= wend)
                hits++;
        end
        if (hits > int'(COUNT_MAX))
            hits = int'(COUNT_MAX);
        return CNT_W'(hits);
    endfunction

    // Pick a timestamp: mostly inside the reachable window span, some never-happened
    // markers, some far beyond any window.
    function automatic logic signed [TIME_W-1:0] pick_stamp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return STAMP_NONE;
        else if (sel < 20)
            return TIME_W'($urandom_range(65535, 7201));
        else
            return TIME_W'($urandom_range(7200));
    endfunction

    // Hand in one word and update the predictor at the edge that accepts it.
    // Start stays high on return so back-to-back words need no second assignment.
    task automatic send_word(logic k, logic [IDX_W-1:0] idx, logic signed [TIME_W-1:0] t,
                             logic [GRP_W-1:0] grp, logic [WIN_W-1:0] ws);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start        <= 1'b1;
        kind         <= k;
        entry_index  <= idx;
        entry_time   <= t;
        group        <= grp;
        window_start <= ws;
        do @(posedge clk); while (busy !== 1'b0);
        if (k == KIND_QUERY)
            count_q.insert(count_q.size(), count_in_window(grp, ws));
        else if (int'(idx) < STORE_DEPTH)
            stamp_mem[idx] = t;
    endtask

    // Load word: group and window start are don't-care, so fill them with noise.
    task automatic load_word(logic [IDX_W-1:0] idx, logic signed [TIME_W-1:0] t);
        send_word(KIND_LOAD, idx, t, GRP_W'($urandom), WIN_W'($urandom));
    endtask

    // Query word: entry index and time are don't-care, so fill them with noise.
    task automatic query_word(logic [GRP_W-1:0] grp, logic [WIN_W-1:0] ws);
        send_word(KIND_QUERY, IDX_W'($urandom), TIME_W'($urandom), grp, ws);
    endtask

    // Drop start and hold off until every pending count has come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (count_q.size() != 0)
            @(posedge clk);
        // a load leaves nothing pending, so let the block settle before returning
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window_length(logic [WIN_W-1:0] len);
        wait_idle();
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_len = len;
    endtask

    // Write every entry once so no query ever reads an unwritten entry.
    task automatic test_fill_store();
        for (int i = 0; i < STORE_DEPTH; i++)
            load_word(IDX_W'(i), pick_stamp());
    endtask

    // Index and timestamp extremes, plus loads past the end that must be dropped.
    task automatic test_load_edges();
        load_word(IDX_W'(0), STAMP_NONE);
        load_word(IDX_W'(STORE_DEPTH - 1), STAMP_TOP);
        load_word(IDX_W'(1), 17'sd0);
        load_word(IDX_W'(255), 17'sd7200);
        load_word(IDX_W'(256), 17'sd3600);
        load_word(IDX_W'(1024), 17'sd60);
        load_word(IDX_W'(STORE_DEPTH), 17'sd0);
        load_word('1, 17'sd100);
    endtask

    // Every group code, including the all-entries group and the empty ones above it.
    task automatic test_group_queries();
        for (int g = 0; g <= int'(GROUP_TOP); g++)
            query_word(GRP_W'(g), (g % 2 == 0) ? WIN_W'(0) : START_MAX);
        query_word(3'd2, 12'd2047);
    endtask

    // Window length at its extremes and at an all-low-bits value.
    task automatic test_window_length();
        set_window_length(12'd0);
        query_word(3'd1, START_MAX);
        query_word(3'd0, 12'd0);
        set_window_length(LEN_MAX);
        query_word(GROUP_ALL, 12'd0);
        set_window_length(12'd2047);
        query_word(3'd4, 12'd2047);
    endtask

    task automatic random_item();
        int sel;
        logic [GRP_W-1:0] grp;
        logic [WIN_W-1:0] ws;
        // now and then pause until the block has drained
        if ($urandom_range(99) < 3)
            wait_idle();
        if ($urandom_range(99) < 55)
        begin
            if ($urandom_range(99) < 7)
                load_word(IDX_W'($urandom_range(2047, STORE_DEPTH)), pick_stamp());
            else
                load_word(IDX_W'($urandom_range(STORE_DEPTH - 1)), pick_stamp());
        end
        else
        begin
            sel = $urandom_range(99);
            if (sel < 84)
                grp = GRP_W'($urandom_range(NUM_GROUPS - 1));
            else if (sel < 94)
                grp = GROUP_ALL;
            else
                grp = GRP_W'($urandom_range(int'(GROUP_TOP), NUM_GROUPS + 1));
            sel = $urandom_range(99);
            if (sel < 10)
                ws = '0;
            else if (sel < 20)
                ws = START_MAX;
            else
                ws = WIN_W'($urandom_range(int'(START_MAX)));
            query_word(grp, ws);
        end
    endtask

    // Three traffic phases: light sender gaps, heavy sender gaps, then none.
    task automatic test_random_traffic();
        int idle_plan [3] = '{25, 83, 0};
        for (int p = 0; p < 3; p++)
        begin
            sender_idle_pct = idle_plan[p];
            set_window_length(WIN_W'($urandom_range(int'(LEN_MAX))));
            for (int i = 0; i < 150; i++)
            begin
                if (i == 75)
                    set_window_length(WIN_W'($urandom_range(int'(LEN_MAX))));
                random_item();
            end
        end
        sender_idle_pct = 0;
    endtask

    // Compare every strobed count with the oldest pending prediction.
    always @(posedge clk)
    begin
        logic [CNT_W-1:0] want;
        if (rst_n && done === 1'b1)
        begin
            if (count_q.size() == 0)
            begin
                $error("event_count: unexpected result, actual %0d", event_count);
                errors++;
            end
            else
            begin
                want = count_q.pop_front();
                if (event_count !== want)
                begin
                    $error("event_count: expected %0d, actual %0d", want, event_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors          = 0;
        sender_idle_pct = 25;
        win_len         = WINDOW_RESET;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        kind         <= KIND_LOAD;
        entry_index  <= '0;
        entry_time   <= '0;
        group        <= '0;
        window_start <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_store();
        test_load_edges();
        test_group_queries();
        test_window_length();
        test_random_traffic();

        wait_idle();
        // a stray strobe could still come from a full-store scan
        repeat (STORE_DEPTH + 16) @(posedge clk);
        if (errors == 0)
            $display("[windowed_event_time_counter] OK");
        else
            $display("[windowed_event_time_counter] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #100_000_000;
        $display("[windowed_event_time_counter] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/wetc_pkg.sv
design/wetc_store.sv
design/wetc_scan.sv
design/windowed_event_time_counter.sv
tb/windowed_event_time_counter_tb.sv
